@@ sv/sgb_pkg.sv @@
// Shared types and constants for the scaled glyph blitter.
// Used by sgb_ctrl, sgb_dp and scaled_glyph_blitter_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgb_pkg;

    localparam int GLYPH_COLS_DEF = 5;
    localparam int GLYPH_ROWS_DEF = 12;
    localparam int CHAR_CODES_DEF = 256;
    localparam int MAX_SCALE_DEF  = 16;

    localparam int MAX_RESULTS = 60;
    localparam int CNT_W       = 6;
    localparam int BITMAP_W    = 5;

    localparam logic [11:0] FB_LIMIT     = 12'd2048;
    localparam logic [11:0] FB_WIDTH_RST = 12'd320;
    localparam logic [11:0] FB_HEIGHT_RST = 12'd240;

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_OFS    = 8'd32;

    localparam logic [2:0] ADDR_FB_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_FB_HEIGHT = 3'd4;

    typedef struct packed {
        logic load_wr;
        logic take_draw;
        logic look_alt;
        logic set_rows;
        logic row_setup;
        logic row_mul;
        logic row_adv;
        logic col_adv;
        logic emit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic scale_zero;
        logic code_oob;
        logic h_nonzero;
        logic is_upper;
        logic row_vis;
        logic cell_hit;
        logic last_col;
        logic last_row;
        logic out_free;
        logic p_valid;
    } t_stat;

endpackage

`default_nettype wire

@@ sv/sgb_ctrl.sv @@
// Sequencer for the scaled glyph blitter: load writes, lookup, row and cell walk, flush.
// Depends on sgb_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sgb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_action,
    input  wire sgb_pkg::t_stat i_stat,
    output sgb_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_LOOK1    = 7'b0000010,
        S_LOOK2    = 7'b0000100,
        S_ROWSTART = 7'b0001000,
        S_ROWMUL   = 7'b0010000,
        S_CELL     = 7'b0100000,
        S_FLUSH    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_action) begin
                        o_cmd.load_wr = !i_stat.code_oob;
                    end else if (!(i_stat.scale_zero || i_stat.code_oob)) begin
                        o_cmd.take_draw = 1'b1;
                        n_state = S_LOOK1;
                    end
                end
            end
            S_LOOK1: begin
                if (i_stat.h_nonzero) begin
                    o_cmd.set_rows = 1'b1;
                    n_state = S_ROWSTART;
                end else if (i_stat.is_upper) begin
                    o_cmd.look_alt = 1'b1;
                    n_state = S_LOOK2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK2: begin
                if (i_stat.h_nonzero) begin
                    o_cmd.set_rows = 1'b1;
                    n_state = S_ROWSTART;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROWSTART: begin
                o_cmd.row_setup = 1'b1;
                n_state = S_ROWMUL;
            end
            S_ROWMUL: begin
                o_cmd.row_mul = 1'b1;
                if (i_stat.row_vis) begin
                    n_state = S_CELL;
                end else begin
                    o_cmd.row_adv = 1'b1;
                    n_state = i_stat.last_row ? S_FLUSH : S_ROWSTART;
                end
            end
            S_CELL: begin
                if (!(i_stat.cell_hit && i_stat.p_valid && !i_stat.out_free)) begin
                    o_cmd.emit = i_stat.cell_hit;
                    if (i_stat.last_col) begin
                        o_cmd.row_adv = 1'b1;
                        n_state = i_stat.last_row ? S_FLUSH : S_ROWSTART;
                    end else begin
                        o_cmd.col_adv = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_stat.p_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");

    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |=> (r_state == S_IDLE))
        else $error("flush did not end the draw");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_stat.p_valid) |-> i_stat.out_free)
        else $error("pending word pushed into a full output register");

endmodule

`default_nettype wire

@@ sv/sgb_dp.sv @@
// Datapath: glyph stores, lookup, row/column clipping, pending and output words.
// Depends on sgb_pkg; driven by sgb_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module sgb_dp #(
    parameter int GLYPH_COLS = sgb_pkg::GLYPH_COLS_DEF,
    parameter int GLYPH_ROWS = sgb_pkg::GLYPH_ROWS_DEF,
    parameter int CHAR_CODES = sgb_pkg::CHAR_CODES_DEF,
    parameter int MAX_SCALE  = sgb_pkg::MAX_SCALE_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sgb_pkg::t_cmd i_cmd,
    output sgb_pkg::t_stat     o_stat,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [3:0]    i_row_index,
    input  wire logic [4:0]    i_row_bits,
    input  wire logic [3:0]    i_row_count,
    input  wire logic signed [11:0] i_pos_x,
    input  wire logic signed [11:0] i_pos_y,
    input  wire logic [15:0]   i_color,
    input  wire logic [4:0]    i_scale_x,
    input  wire logic [4:0]    i_scale_y,
    input  wire logic [11:0]   i_fw,
    input  wire logic [11:0]   i_fh,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [21:0]        o_start_address,
    output logic [10:0]        o_rect_x,
    output logic [10:0]        o_rect_y,
    output logic [4:0]         o_rect_w,
    output logic [4:0]         o_rect_h,
    output logic [15:0]        o_fill_color,
    output logic               o_last
);

    localparam int NC    = (GLYPH_COLS < sgb_pkg::BITMAP_W) ? GLYPH_COLS : sgb_pkg::BITMAP_W;
    localparam int CCW   = (NC > 1) ? $clog2(NC) : 1;
    localparam int RRW   = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int CW    = $clog2(CHAR_CODES);
    localparam int DEPTH = CHAR_CODES * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);

    // glyph stores
    logic [3:0]                    r_heights [CHAR_CODES];
    logic [CHAR_CODES-1:0]         r_hvalid;
    logic [sgb_pkg::BITMAP_W-1:0]  r_bitmaps [DEPTH];
    logic [3:0]                    r_h_q;
    logic                          r_hv_q;
    logic [sgb_pkg::BITMAP_W-1:0]  r_bm_q;

    // draw context
    logic [7:0]          r_code;
    logic signed [11:0]  r_px;
    logic [4:0]          r_sx;
    logic [4:0]          r_sy;
    logic [15:0]         r_color;
    logic [3:0]          r_rows;
    logic [RRW-1:0]      r_row;
    logic [CCW-1:0]      r_col;
    logic signed [13:0]  r_row_top;
    logic signed [13:0]  r_col_left;
    logic [10:0]         r_ry;
    logic [4:0]          r_rh;
    logic                r_rvis;
    logic [21:0]         r_row_base;
    logic [sgb_pkg::CNT_W-1:0] r_count;

    // pending word
    logic                r_p_valid;
    logic [21:0]         r_p_addr;
    logic [10:0]         r_p_x;
    logic [10:0]         r_p_y;
    logic [4:0]          r_p_w;
    logic [4:0]          r_p_h;
    logic [15:0]         r_p_color;

    logic [4:0]          sx_sat, sy_sat;
    logic [3:0]          cnt_sat;
    logic                wr_row_ok;
    logic [AW-1:0]       bm_wr_addr, bm_rd_addr;
    logic [7:0]          alt_code;
    logic [CW-1:0]       h_rd_addr;
    logic                h_rd_en;
    logic signed [13:0]  sx_s, sy_s, fw_s, fh_s;
    logic signed [13:0]  ya, yb_raw, yb, xa, xb_raw, xb, xw, yh;
    logic                x_vis, y_vis;
    logic [22:0]         prod;
    logic                out_free;

    assign sx_sat  = ({2'b0, i_scale_x} > 7'(MAX_SCALE)) ? 5'(MAX_SCALE) : i_scale_x;
    assign sy_sat  = ({2'b0, i_scale_y} > 7'(MAX_SCALE)) ? 5'(MAX_SCALE) : i_scale_y;
    assign cnt_sat = ({1'b0, i_row_count} > 5'(GLYPH_ROWS)) ? 4'(GLYPH_ROWS) : i_row_count;
    assign wr_row_ok  = ({1'b0, i_row_index} < 5'(GLYPH_ROWS));
    assign bm_wr_addr = AW'(32'(i_char_code) * GLYPH_ROWS + 32'(i_row_index));
    assign bm_rd_addr = AW'(32'(r_code) * GLYPH_ROWS + 32'(r_row));
    assign alt_code   = r_code + sgb_pkg::LOWER_OFS;
    assign h_rd_addr  = i_cmd.look_alt ? alt_code[CW-1:0] : i_char_code[CW-1:0];
    assign h_rd_en    = i_cmd.take_draw || i_cmd.look_alt;

    assign sx_s = $signed({9'd0, r_sx});
    assign sy_s = $signed({9'd0, r_sy});
    assign fw_s = $signed({2'b0, i_fw});
    assign fh_s = $signed({2'b0, i_fh});

    // vertical clip of the current row
    assign ya     = r_row_top[13] ? 14'sd0 : r_row_top;
    assign yb_raw = r_row_top + sy_s;
    assign yb     = (yb_raw > fh_s) ? fh_s : yb_raw;
    assign y_vis  = (yb > ya);
    assign yh     = yb - ya;

    // horizontal clip of the current cell
    assign xa     = r_col_left[13] ? 14'sd0 : r_col_left;
    assign xb_raw = r_col_left + sx_s;
    assign xb     = (xb_raw > fw_s) ? fw_s : xb_raw;
    assign x_vis  = (xb > xa);
    assign xw     = xb - xa;

    assign prod     = 23'(r_ry) * 23'(i_fw);
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        o_stat = '0;
        o_stat.scale_zero = (i_scale_x == 5'd0) || (i_scale_y == 5'd0);
        o_stat.code_oob   = ({1'b0, i_char_code} >= 9'(CHAR_CODES));
        o_stat.h_nonzero  = r_hv_q && (r_h_q != 4'd0);
        o_stat.is_upper   = (r_code >= sgb_pkg::CHAR_UPPER_A) &&
                            (r_code <= sgb_pkg::CHAR_UPPER_Z);
        o_stat.row_vis    = r_rvis;
        o_stat.cell_hit   = r_bm_q[r_col] && x_vis &&
                            (r_count < sgb_pkg::CNT_W'(sgb_pkg::MAX_RESULTS));
        o_stat.last_col   = (r_col == CCW'(NC - 1));
        o_stat.last_row   = ((5'(r_row) + 5'd1) == {1'b0, r_rows});
        o_stat.out_free   = out_free;
        o_stat.p_valid    = r_p_valid;
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_heights[i_char_code[CW-1:0]] <= cnt_sat;
        end
        if (h_rd_en) begin
            r_h_q <= r_heights[h_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
            r_hv_q   <= 1'b0;
        end else begin
            if (i_cmd.load_wr) begin
                r_hvalid[i_char_code[CW-1:0]] <= 1'b1;
            end
            if (h_rd_en) begin
                r_hv_q <= r_hvalid[h_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_row_ok) begin
            r_bitmaps[bm_wr_addr] <= i_row_bits;
        end
        if (i_cmd.row_setup) begin
            r_bm_q <= r_bitmaps[bm_rd_addr];
        end
    end

    // walk state
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_draw) begin
            r_code     <= i_char_code;
            r_px       <= i_pos_x;
            r_sx       <= sx_sat;
            r_sy       <= sy_sat;
            r_color    <= i_color;
            r_row      <= '0;
            r_col      <= '0;
            r_row_top  <= 14'(i_pos_y);
            r_col_left <= 14'(i_pos_x);
        end
        if (i_cmd.look_alt) begin
            r_code <= alt_code;
        end
        if (i_cmd.set_rows) begin
            r_rows <= r_h_q;
        end
        if (i_cmd.row_setup) begin
            r_ry   <= ya[10:0];
            r_rh   <= yh[4:0];
            r_rvis <= y_vis;
        end
        if (i_cmd.row_mul) begin
            r_row_base <= prod[21:0];
        end
        if (i_cmd.row_adv) begin
            r_row      <= r_row + RRW'(1);
            r_row_top  <= r_row_top + sy_s;
            r_col      <= '0;
            r_col_left <= 14'(r_px);
        end
        if (i_cmd.col_adv) begin
            r_col      <= r_col + CCW'(1);
            r_col_left <= r_col_left + sx_s;
        end
        if (i_cmd.emit) begin
            r_p_addr  <= r_row_base + 22'(xa[10:0]);
            r_p_x     <= xa[10:0];
            r_p_y     <= r_ry;
            r_p_w     <= xw[4:0];
            r_p_h     <= r_rh;
            r_p_color <= r_color;
        end
        if ((i_cmd.emit && r_p_valid) || i_cmd.flush) begin
            o_start_address <= r_p_addr;
            o_rect_x        <= r_p_x;
            o_rect_y        <= r_p_y;
            o_rect_w        <= r_p_w;
            o_rect_h        <= r_p_h;
            o_fill_color    <= r_p_color;
            o_last          <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_draw) begin
                r_count <= '0;
            end else if (i_cmd.emit) begin
                r_count <= r_count + sgb_pkg::CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_p_valid <= 1'b1;
            end else if (i_cmd.flush || i_cmd.take_draw) begin
                r_p_valid <= 1'b0;
            end
            if ((i_cmd.emit && r_p_valid) || i_cmd.flush) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_count < sgb_pkg::CNT_W'(sgb_pkg::MAX_RESULTS)))
        else $error("more rectangles than allowed in one draw");

    a_flush_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> r_p_valid)
        else $error("flush without pending word");

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.flush) |=> (o_out_valid || r_p_valid))
        else $error("word lost");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (xw != 14'sd0) && (r_rh != 5'd0))
        else $error("empty rectangle emitted");

endmodule

`default_nettype wire

@@ sv/scaled_glyph_blitter_core.sv @@
// Top level of the scaled glyph blitter: APB registers, sequencer and datapath.
// Depends on sgb_pkg, sgb_ctrl and sgb_dp.
//
//  channel | direction | handshake                 | word
//  in      | input     | i_in_valid / o_in_stall   | load row or draw request
//  out     | output    | o_out_valid / i_out_stall | one clipped rectangle
//  cfg     | input     | psel/penable/pwrite/pready| fb_width (0x0), fb_height (0x4)
//
// Load: written from the idle state. Draw: a height lookup, retried once for an
// upper-case code as lower case, then per glyph row a bitmap read and a row
// address multiply, a cell step per column of each visible row, and a flush.
// A stalled output holds the walk when a second rectangle is ready.
// Reset clears all glyph presence bits at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module scaled_glyph_blitter_core #(
    parameter int GLYPH_COLS = sgb_pkg::GLYPH_COLS_DEF,
    parameter int GLYPH_ROWS = sgb_pkg::GLYPH_ROWS_DEF,
    parameter int CHAR_CODES = sgb_pkg::CHAR_CODES_DEF,
    parameter int MAX_SCALE  = sgb_pkg::MAX_SCALE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [3:0]  i_row_index,
    input  wire logic [4:0]  i_row_bits,
    input  wire logic [3:0]  i_row_count,
    input  wire logic signed [11:0] i_pos_x,
    input  wire logic signed [11:0] i_pos_y,
    input  wire logic [15:0] i_color,
    input  wire logic [4:0]  i_scale_x,
    input  wire logic [4:0]  i_scale_y,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [21:0]      o_start_address,
    output logic [10:0]      o_rect_x,
    output logic [10:0]      o_rect_y,
    output logic [4:0]       o_rect_w,
    output logic [4:0]       o_rect_h,
    output logic [15:0]      o_fill_color,
    output logic             o_last
);

    logic [11:0]    r_fb_width;
    logic [11:0]    r_fb_height;
    logic [11:0]    fw, fh;
    logic           cfg_wr;
    sgb_pkg::t_cmd  cmd;
    sgb_pkg::t_stat stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {20'd0, r_fb_height} : {20'd0, r_fb_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= sgb_pkg::FB_WIDTH_RST;
            r_fb_height <= sgb_pkg::FB_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == sgb_pkg::ADDR_FB_HEIGHT[2]) begin
                r_fb_height <= pwdata[11:0];
            end else begin
                r_fb_width <= pwdata[11:0];
            end
        end
    end

    assign fw = (r_fb_width  > sgb_pkg::FB_LIMIT) ? sgb_pkg::FB_LIMIT : r_fb_width;
    assign fh = (r_fb_height > sgb_pkg::FB_LIMIT) ? sgb_pkg::FB_LIMIT : r_fb_height;

    sgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    sgb_dp #(
        .GLYPH_COLS (GLYPH_COLS),
        .GLYPH_ROWS (GLYPH_ROWS),
        .CHAR_CODES (CHAR_CODES),
        .MAX_SCALE  (MAX_SCALE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_char_code     (i_char_code),
        .i_row_index     (i_row_index),
        .i_row_bits      (i_row_bits),
        .i_row_count     (i_row_count),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_color         (i_color),
        .i_scale_x       (i_scale_x),
        .i_scale_y       (i_scale_y),
        .i_fw            (fw),
        .i_fh            (fh),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_start_address (o_start_address),
        .o_rect_x        (o_rect_x),
        .o_rect_y        (o_rect_y),
        .o_rect_w        (o_rect_w),
        .o_rect_h        (o_rect_h),
        .o_fill_color    (o_fill_color),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

@@ tb/sgb_tb_pkg.sv @@
// Testbench-side codes for the scaled glyph blitter: the word action field.
// No dependencies; used by sgb_rect_checker and scaled_glyph_blitter_core_tb.
`timescale 1ns / 1ps

package sgb_tb_pkg;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } t_action;

endpackage

@@ tb/sgb_rect_checker.sv @@
// Checker for the scaled glyph blitter: tracks registers and glyph store, predicts
// the clipped rectangles of each draw word and compares them with the output channel.
// Depends on sgb_pkg and sgb_tb_pkg.
`timescale 1ns / 1ps

module sgb_rect_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_action,
    input  logic [7:0]         i_char_code,
    input  logic [3:0]         i_row_index,
    input  logic [4:0]         i_row_bits,
    input  logic [3:0]         i_row_count,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic [15:0]        i_color,
    input  logic [4:0]         i_scale_x,
    input  logic [4:0]         i_scale_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [21:0]        i_start_address,
    input  logic [10:0]        i_rect_x,
    input  logic [10:0]        i_rect_y,
    input  logic [4:0]         i_rect_w,
    input  logic [4:0]         i_rect_h,
    input  logic [15:0]        i_fill_color,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int ROWS      = sgb_pkg::GLYPH_ROWS_DEF;
    localparam int COLS      = sgb_pkg::GLYPH_COLS_DEF;
    localparam int CODES     = sgb_pkg::CHAR_CODES_DEF;
    localparam int SCALE_MAX = sgb_pkg::MAX_SCALE_DEF;

    typedef struct packed {
        logic [21:0] start_address;
        logic [10:0] rect_x;
        logic [10:0] rect_y;
        logic [4:0]  rect_w;
        logic [4:0]  rect_h;
        logic [15:0] fill_color;
        logic        last;
    } t_glyph_rect;

    logic [4:0]  bitmap_mem [CODES * ROWS];
    logic [3:0]  height_mem [CODES];
    logic [11:0] fb_width;
    logic [11:0] fb_height;
    t_glyph_rect expected_rects [$];

    // [lo, lo + len) against [0, bound)
    function automatic bit clip_span(input int lo, input int len, input int bound,
                                     output int start, output int size);
        int hi;
        start = (lo < 0) ? 0 : lo;
        hi = lo + len;
        if (hi > bound) hi = bound;
        size = hi - start;
        return hi > start;
    endfunction

    task automatic trace_glyph_rects(input logic [7:0] code_in,
                                     input logic signed [11:0] px,
                                     input logic signed [11:0] py,
                                     input logic [15:0] col,
                                     input logic [4:0] scx,
                                     input logic [4:0] scy);
        t_glyph_rect cells [sgb_pkg::MAX_RESULTS];
        logic [7:0]  code;
        logic [4:0]  bits;
        int n, sx, sy, fw, fh, rows, ry, rh, rx, rw;
        n = 0;
        code = code_in;
        sx = (scx > SCALE_MAX) ? SCALE_MAX : int'(scx);
        sy = (scy > SCALE_MAX) ? SCALE_MAX : int'(scy);
        fw = (fb_width > sgb_pkg::FB_LIMIT) ? int'(sgb_pkg::FB_LIMIT) : int'(fb_width);
        fh = (fb_height > sgb_pkg::FB_LIMIT) ? int'(sgb_pkg::FB_LIMIT) : int'(fb_height);
        if (sx == 0 || sy == 0) return;
        if (height_mem[code] == 0) begin
            if (code >= sgb_pkg::CHAR_UPPER_A && code <= sgb_pkg::CHAR_UPPER_Z)
                code = code + sgb_pkg::LOWER_OFS;
            if (height_mem[code] == 0) return;
        end
        rows = (height_mem[code] > ROWS) ? ROWS : int'(height_mem[code]);
        for (int r = 0; r < rows; r++) begin
            bits = bitmap_mem[int'(code) * ROWS + r];
            if (!clip_span(int'(py) + r * sy, sy, fh, ry, rh)) continue;
            for (int c = 0; c < COLS; c++) begin
                if (!bits[c]) continue;
                if (!clip_span(int'(px) + c * sx, sx, fw, rx, rw)) continue;
                if (n >= sgb_pkg::MAX_RESULTS) continue;
                cells[n].start_address = 22'(ry * fw + rx);
                cells[n].rect_x        = 11'(rx);
                cells[n].rect_y        = 11'(ry);
                cells[n].rect_w        = 5'(rw);
                cells[n].rect_h        = 5'(rh);
                cells[n].fill_color    = col;
                cells[n].last          = 1'b0;
                n++;
            end
        end
        if (n > 0) cells[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_rects = {expected_rects, cells[i]};
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph_rect want;
        if (!i_rst_n) begin
            foreach (height_mem[k]) height_mem[k] = '0;
            foreach (bitmap_mem[k]) bitmap_mem[k] = '0;
            fb_width  = sgb_pkg::FB_WIDTH_RST;
            fb_height = sgb_pkg::FB_HEIGHT_RST;
            expected_rects.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    sgb_pkg::ADDR_FB_WIDTH: begin
                        fb_width = i_pwdata[11:0];
                    end
                    sgb_pkg::ADDR_FB_HEIGHT: begin
                        fb_height = i_pwdata[11:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_rects.size() == 0) begin
                    $error("rectangle with none expected: x=%0d y=%0d w=%0d h=%0d",
                           i_rect_x, i_rect_y, i_rect_w, i_rect_h);
                    o_fail_count++;
                end else begin
                    want = expected_rects.pop_front();
                    check_field("start_address", want.start_address, i_start_address);
                    check_field("rect_x", want.rect_x, i_rect_x);
                    check_field("rect_y", want.rect_y, i_rect_y);
                    check_field("rect_w", want.rect_w, i_rect_w);
                    check_field("rect_h", want.rect_h, i_rect_h);
                    check_field("fill_color", want.fill_color, i_fill_color);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == sgb_tb_pkg::ACT_LOAD) begin
                    if (i_row_index < ROWS)
                        bitmap_mem[int'(i_char_code) * ROWS + int'(i_row_index)] = i_row_bits;
                    height_mem[i_char_code] = (i_row_count > ROWS) ? 4'(ROWS) : i_row_count;
                end else begin
                    trace_glyph_rects(i_char_code, i_pos_x, i_pos_y, i_color,
                                      i_scale_x, i_scale_y);
                end
            end
        end
        o_pending = expected_rects.size();
    end

endmodule

@@ tb/scaled_glyph_blitter_core_tb.sv @@
// Top of the scaled glyph blitter testbench: clock, reset, APB writes, word stimulus
// and random stalls; the verdict comes from sgb_rect_checker.
// Depends on sgb_pkg, sgb_tb_pkg, sgb_rect_checker and scaled_glyph_blitter_core.
`timescale 1ns / 1ps

module scaled_glyph_blitter_core_tb;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 50;
    localparam int NUM_PHASES   = 7;
    localparam int HOLD_PHASE   = 4;
    localparam int PAUSE_PHASE  = 6;
    localparam int PLAN_W  [NUM_PHASES] = '{64, 1, 4095, 0, 2048, 100, 37};
    localparam int PLAN_H  [NUM_PHASES] = '{48, 1, 4095, 100, 2048, 0, 29};
    localparam int PLAN_TX [NUM_PHASES] = '{0, 68, 0, 20, 0, 20, 0};
    localparam int PLAN_RX [NUM_PHASES] = '{0, 0, 68, 20, 0, 20, 0};
    localparam int ROWS_DEF = sgb_pkg::GLYPH_ROWS_DEF;
    localparam logic [7:0] CHAR_UPPER_A = sgb_pkg::CHAR_UPPER_A;
    localparam logic [7:0] CHAR_LOWER_A = sgb_pkg::CHAR_UPPER_A + sgb_pkg::LOWER_OFS;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = 1'b0;
    logic [7:0]         i_char_code = '0;
    logic [3:0]         i_row_index = '0;
    logic [4:0]         i_row_bits = '0;
    logic [3:0]         i_row_count = '0;
    logic signed [11:0] i_pos_x = '0;
    logic signed [11:0] i_pos_y = '0;
    logic [15:0]        i_color = '0;
    logic [4:0]         i_scale_x = '0;
    logic [4:0]         i_scale_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [21:0]        o_start_address;
    logic [10:0]        o_rect_x;
    logic [10:0]        o_rect_y;
    logic [4:0]         o_rect_w;
    logic [4:0]         o_rect_h;
    logic [15:0]        o_fill_color;
    logic               o_last;

    int          fail_count;
    int          pending;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_taken = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          words_sent = 0;
    logic [11:0] cur_fb_w = sgb_pkg::FB_WIDTH_RST;
    logic [11:0] cur_fb_h = sgb_pkg::FB_HEIGHT_RST;
    logic [11:0] rows_loaded [256];
    logic [7:0]  glyph_codes [$];

    always #1 i_clk = ~i_clk;

    scaled_glyph_blitter_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_row_index     (i_row_index),
        .i_row_bits      (i_row_bits),
        .i_row_count     (i_row_count),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_color         (i_color),
        .i_scale_x       (i_scale_x),
        .i_scale_y       (i_scale_y),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_start_address (o_start_address),
        .o_rect_x        (o_rect_x),
        .o_rect_y        (o_rect_y),
        .o_rect_w        (o_rect_w),
        .o_rect_h        (o_rect_h),
        .o_fill_color    (o_fill_color),
        .o_last          (o_last)
    );

    sgb_rect_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_row_index     (i_row_index),
        .i_row_bits      (i_row_bits),
        .i_row_count     (i_row_count),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_color         (i_color),
        .i_scale_x       (i_scale_x),
        .i_scale_y       (i_scale_y),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_start_address (o_start_address),
        .i_rect_x        (o_rect_x),
        .i_rect_y        (o_rect_y),
        .i_rect_w        (o_rect_w),
        .i_rect_h        (o_rect_h),
        .i_fill_color    (o_fill_color),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // output side: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(input logic [2:0] addr, input logic [11:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {20'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_word(input sgb_tb_pkg::t_action act, input logic [7:0] code,
                             input logic [3:0] row, input logic [4:0] bits,
                             input logic [3:0] cnt, input logic [11:0] px,
                             input logic [11:0] py, input logic [15:0] col,
                             input logic [4:0] scx, input logic [4:0] scy);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_char_code <= code;
        i_row_index <= row;
        i_row_bits <= bits;
        i_row_count <= cnt;
        i_pos_x <= px;
        i_pos_y <= py;
        i_color <= col;
        i_scale_x <= scx;
        i_scale_y <= scy;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        words_sent++;
    endtask

    // callers keep every glyph fully loaded: the count never exceeds the written rows
    task automatic load_row(input logic [7:0] code, input logic [3:0] row,
                            input logic [4:0] bits, input logic [3:0] cnt);
        if (row < ROWS_DEF) rows_loaded[code][row] = 1'b1;
        send_word(sgb_tb_pkg::ACT_LOAD, code, row, bits, cnt, 12'($urandom),
                  12'($urandom), 16'($urandom), 5'($urandom), 5'($urandom));
    endtask

    task automatic draw_char(input logic [7:0] code, input logic [11:0] px,
                             input logic [11:0] py, input logic [15:0] col,
                             input logic [4:0] scx, input logic [4:0] scy);
        send_word(sgb_tb_pkg::ACT_DRAW, code, 4'($urandom), 5'($urandom), 4'($urandom),
                  px, py, col, scx, scy);
    endtask

    function automatic logic [11:0] pick_pos(input logic [11:0] fb);
        int span;
        span = (fb > sgb_pkg::FB_LIMIT) ? 2048 : int'(fb);
        if ($urandom_range(4) == 0) return 12'($urandom);
        return 12'($urandom_range(span + 40) - 24);
    endfunction

    function automatic logic [4:0] pick_scale();
        if ($urandom_range(9) == 0) return 5'($urandom);
        return 5'($urandom_range(6, 1));
    endfunction

    task automatic random_draw(input logic [7:0] code);
        draw_char(code, pick_pos(cur_fb_w), pick_pos(cur_fb_h), 16'($urandom),
                  pick_scale(), pick_scale());
    endtask

    task automatic define_glyph();
        logic [7:0] code;
        logic [3:0] cnt;
        int depth;
        if ($urandom_range(3) != 0) begin
            code = CHAR_LOWER_A + 8'($urandom_range(25));
        end else begin
            code = 8'($urandom);
        end
        depth = $urandom_range(ROWS_DEF, 1);
        for (int r = 0; r < depth; r++) begin
            cnt = 4'(r + 1);
            if (r == ROWS_DEF - 1) cnt = 4'($urandom_range(15, 12));
            load_row(code, 4'(r), 5'($urandom), cnt);
        end
        glyph_codes = {glyph_codes, code};
        repeat ($urandom_range(3, 1)) begin
            if (code >= CHAR_LOWER_A && code < CHAR_LOWER_A + 26 && $urandom_range(1) == 1) begin
                random_draw(code - sgb_pkg::LOWER_OFS);
            end else begin
                random_draw(code);
            end
        end
    endtask

    task automatic stray_load();
        logic [7:0]  code;
        logic [3:0]  row;
        logic [11:0] mask;
        logic [3:0]  cnt;
        int prefix;
        if (glyph_codes.size() > 0 && $urandom_range(1) == 1) begin
            code = glyph_codes[$urandom_range(glyph_codes.size() - 1)];
        end else begin
            code = 8'($urandom);
        end
        row = 4'($urandom);
        mask = rows_loaded[code];
        if (row < ROWS_DEF) mask[row] = 1'b1;
        prefix = 0;
        while (prefix < ROWS_DEF && mask[prefix]) prefix++;
        if (prefix == ROWS_DEF) begin
            cnt = 4'($urandom_range(15));
        end else begin
            cnt = 4'($urandom_range(prefix));
        end
        load_row(code, row, 5'($urandom), cnt);
    endtask

    task automatic pick_draw();
        logic [7:0] code;
        int pick;
        pick = $urandom_range(9);
        if (pick < 5 && glyph_codes.size() > 0) begin
            code = glyph_codes[$urandom_range(glyph_codes.size() - 1)];
        end else if (pick < 7) begin
            code = CHAR_UPPER_A + 8'($urandom_range(25));
        end else begin
            code = 8'($urandom);
        end
        random_draw(code);
    endtask

    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int start;
        int pick;
        bit paused;
        foreach (rows_loaded[k]) rows_loaded[k] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full 5x12 glyph, every cell lit
        for (int r = 0; r < ROWS_DEF; r++) begin
            load_row(CHAR_LOWER_A, 4'(r), 5'h1f, 4'(r + 1));
        end
        glyph_codes = {glyph_codes, CHAR_LOWER_A};
        draw_char(CHAR_LOWER_A, 12'd0, 12'd0, 16'hffff, 5'd16, 5'd16);
        draw_char(CHAR_UPPER_A, -12'sd3, -12'sd5, 16'h0000, 5'd31, 5'd31);
        draw_char(CHAR_LOWER_A, 12'h800, 12'h800, 16'h1234, 5'd1, 5'd1);
        draw_char(CHAR_LOWER_A, 12'd310, 12'd230, 16'h8001, 5'd4, 5'd4);
        draw_char(CHAR_LOWER_A, 12'd10, 12'd10, 16'h5a5a, 5'd0, 5'd5);
        draw_char(CHAR_LOWER_A, 12'd10, 12'd10, 16'ha5a5, 5'd3, 5'd0);
        draw_char(CHAR_UPPER_A + 8'd16, 12'd0, 12'd0, 16'h00ff, 5'd2, 5'd2);
        // row out of range, count saturates
        load_row(CHAR_LOWER_A, 4'd15, 5'd0, 4'd15);
        draw_char(CHAR_LOWER_A, 12'd100, 12'd50, 16'h7fff, 5'd2, 5'd3);
        load_row(CHAR_UPPER_A, 4'd0, 5'b10101, 4'd1);
        draw_char(CHAR_UPPER_A, 12'd1, 12'd1, 16'hff00, 5'd1, 5'd1);
        load_row(CHAR_UPPER_A, 4'd0, 5'd0, 4'd0);
        draw_char(CHAR_UPPER_A, 12'hfff, 12'd0, 16'h0f0f, 5'd1, 5'd2);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain(DRAIN_CYCLES);
            write_reg(sgb_pkg::ADDR_FB_WIDTH, 12'(PLAN_W[p]));
            write_reg(sgb_pkg::ADDR_FB_HEIGHT, 12'(PLAN_H[p]));
            cur_fb_w = 12'(PLAN_W[p]);
            cur_fb_h = 12'(PLAN_H[p]);
            tx_idle_pct = PLAN_TX[p];
            rx_stall_pct <= PLAN_RX[p];
            if (p == HOLD_PHASE) hold_req <= 1'b1;
            start = words_sent;
            paused = 1'b0;
            while (words_sent - start < PHASE_ITEMS) begin
                if (p == PAUSE_PHASE && !paused && words_sent - start >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain(1);
                end
                pick = $urandom_range(99);
                if (pick < 15) begin
                    define_glyph();
                end else if (pick < 70) begin
                    pick_draw();
                end else begin
                    stray_load();
                end
            end
        end

        drain(DRAIN_CYCLES);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
